// ===== src/ppm_pkg.sv =====
// Package for the PPM P3 text encoder: shared types, constants and the
// decimal digit split used by the front part. No dependencies.
package ppm_pkg;

    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int FRACTION_BITS_DEF = 12;

    localparam int LEVEL_W  = 16;
    localparam int WIDTH_W  = 13;
    localparam int LIMIT_W  = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int QDEPTH   = 2;
    localparam int QAW      = 1;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd70;

    localparam logic REG_IMAGE_WIDTH = 1'b0;
    localparam logic REG_LINE_LIMIT  = 1'b1;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef struct packed {
        logic [WIDTH_W-1:0] image_width;
        logic [LIMIT_W-1:0] line_limit;
    } t_cfg;

    // One decimal token: digit count and its digits, first emitted at index 0.
    typedef struct packed {
        logic [1:0]      len;
        logic [2:0][3:0] chars;
    } t_token;

    typedef t_token [2:0] t_pixel;

    typedef enum logic [1:0] {
        PH_DIGIT,
        PH_SEP,
        PH_TAIL
    } t_phase;

    function automatic t_token to_token(logic [7:0] v);
        logic [6:0]  rem;
        logic [1:0]  hund;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [3:0]  ones;
        t_token      t;
        if (v >= 8'd200) begin
            hund = 2'd2;
            rem  = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            hund = 2'd1;
            rem  = 7'(v - 8'd100);
        end else begin
            hund = 2'd0;
            rem  = v[6:0];
        end
        prod = {8'b0, rem} * 15'd205;
        tens = prod[14:11];
        ones = 4'(rem - 7'({3'b0, tens} * 7'd10));
        if (hund != 2'd0) begin
            t.len   = 2'd3;
            t.chars = {ones, tens, {2'b0, hund}};
        end else if (tens != 4'd0) begin
            t.len   = 2'd2;
            t.chars = {4'd0, ones, tens};
        end else begin
            t.len   = 2'd1;
            t.chars = {4'd0, 4'd0, ones};
        end
        return t;
    endfunction

endpackage

// ===== src/ppm_ifs.sv =====
// Handshake channels of the PPM P3 text encoder: pixel words in, text words out.
// Depends on no other file.
interface ppm_pix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] red_level;
    logic signed [15:0] green_level;
    logic signed [15:0] blue_level;

    modport source(output valid, output red_level, output green_level,
                   output blue_level, input ready);
    modport sink(input valid, input red_level, input green_level,
                 input blue_level, output ready);
endinterface

interface ppm_txt_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       pixel_done;

    modport source(output valid, output text_byte, output pixel_done, input ready);
    modport sink(input valid, input text_byte, input pixel_done, output ready);
endinterface

// ===== src/ppm_front.sv =====
// Front part: accepts pixel words, clamps each component to 0..255 and
// splits it into decimal digits. Depends on ppm_pkg and ppm_pix_if.
module ppm_front #(
    parameter int FRACTION_BITS = ppm_pkg::FRACTION_BITS_DEF
) (
    ppm_pix_if.sink         i_pix,
    input  logic            i_q_ready,
    output logic            o_push,
    output ppm_pkg::t_pixel o_data
);

    localparam int SHIFT = FRACTION_BITS - 8;

    function automatic logic [7:0] to_level(logic signed [15:0] raw);
        logic [14:0] q;
        q = raw[14:0] >> SHIFT;
        if (raw[15]) begin
            return 8'd0;
        end
        return (q > 15'd255) ? 8'd255 : q[7:0];
    endfunction

    assign i_pix.ready = i_q_ready;
    assign o_push      = i_pix.valid && i_q_ready;

    always_comb begin
        o_data[0] = ppm_pkg::to_token(to_level(i_pix.red_level));
        o_data[1] = ppm_pkg::to_token(to_level(i_pix.green_level));
        o_data[2] = ppm_pkg::to_token(to_level(i_pix.blue_level));
    end

endmodule

// ===== src/ppm_queue.sv =====
// Two-entry queue of decoded pixels between the front and back parts.
// Depends on ppm_pkg.
module ppm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppm_pkg::t_pixel i_data,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output ppm_pkg::t_pixel o_head
);

    ppm_pkg::t_pixel            r_mem [ppm_pkg::QDEPTH];
    logic [ppm_pkg::QAW-1:0]    r_wptr;
    logic [ppm_pkg::QAW-1:0]    r_rptr;
    logic [ppm_pkg::QAW:0]      r_count;
    logic [ppm_pkg::QAW:0]      n_count;

    assign o_ready = (r_count != (ppm_pkg::QAW+1)'(ppm_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/ppm_back.sv =====
// Back part: emits one text word per unstalled cycle for the queued pixel,
// tracks line length and row position. Depends on ppm_pkg and ppm_txt_if.
module ppm_back #(
    parameter int MAX_WIDTH = ppm_pkg::MAX_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppm_pkg::t_cfg   i_cfg,
    input  logic            i_head_valid,
    input  ppm_pkg::t_pixel i_head,
    output logic            o_pop,
    ppm_txt_if.source       o_txt
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ((CW > ppm_pkg::WIDTH_W) ? CW : ppm_pkg::WIDTH_W) + 2;

    ppm_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_comp, n_comp;
    logic [1:0]      r_pos, n_pos;
    logic [7:0]      r_ll, n_ll;
    logic [CW-1:0]   r_col, n_col;
    logic            r_out_valid;
    logic [7:0]      r_byte, n_byte;
    logic            r_done, n_done;

    logic            fire;
    ppm_pkg::t_token tok;
    logic [9:0]      sep_sum;
    logic [9:0]      tail_sum;
    logic [9:0]      limit;
    logic [WW-1:0]   eff_width;
    logic [WW-1:0]   col_next;
    logic            end_row;

    assign fire = i_head_valid && (!r_out_valid || o_txt.ready);
    assign tok  = i_head[r_comp];

    assign sep_sum  = {2'b0, r_ll} + 10'd1 + {8'b0, tok.len};
    assign tail_sum = {2'b0, r_ll} + 10'd4;
    assign limit    = {2'b0, i_cfg.line_limit};

    always_comb begin
        if (i_cfg.image_width == '0) begin
            eff_width = WW'(1);
        end else if (WW'(i_cfg.image_width) > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(i_cfg.image_width);
        end
    end

    assign col_next = WW'(r_col) + WW'(1);
    assign end_row  = (col_next >= eff_width);

    always_comb begin
        n_phase = r_phase;
        n_comp  = r_comp;
        n_pos   = r_pos;
        n_ll    = r_ll;
        n_col   = r_col;
        n_byte  = ppm_pkg::CHAR_SPACE;
        n_done  = 1'b0;
        o_pop   = 1'b0;
        if (fire) begin
            unique case (r_phase)
                ppm_pkg::PH_DIGIT: begin
                    n_byte = ppm_pkg::CHAR_ZERO | {4'b0, tok.chars[r_pos]};
                    n_ll   = r_ll + 8'd1;
                    if (r_pos == tok.len - 2'd1) begin
                        n_pos = 2'd0;
                        if (r_comp == 2'd2) begin
                            n_phase = ppm_pkg::PH_TAIL;
                        end else begin
                            n_phase = ppm_pkg::PH_SEP;
                            n_comp  = r_comp + 2'd1;
                        end
                    end else begin
                        n_pos = r_pos + 2'd1;
                    end
                end
                ppm_pkg::PH_SEP: begin
                    n_phase = ppm_pkg::PH_DIGIT;
                    if (sep_sum > limit) begin
                        n_byte = ppm_pkg::CHAR_NEWLINE;
                        n_ll   = 8'd0;
                    end else begin
                        n_byte = ppm_pkg::CHAR_SPACE;
                        n_ll   = r_ll + 8'd1;
                    end
                end
                ppm_pkg::PH_TAIL: begin
                    n_phase = ppm_pkg::PH_DIGIT;
                    n_comp  = 2'd0;
                    n_done  = 1'b1;
                    o_pop   = 1'b1;
                    if (end_row) begin
                        n_byte = ppm_pkg::CHAR_NEWLINE;
                        n_ll   = 8'd0;
                        n_col  = '0;
                    end else begin
                        n_col = r_col + CW'(1);
                        if (tail_sum > limit) begin
                            n_byte = ppm_pkg::CHAR_NEWLINE;
                            n_ll   = 8'd0;
                        end else begin
                            n_byte = ppm_pkg::CHAR_SPACE;
                            n_ll   = r_ll + 8'd1;
                        end
                    end
                end
                default: begin
                    n_phase = ppm_pkg::PH_DIGIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ppm_pkg::PH_DIGIT;
            r_comp      <= 2'd0;
            r_pos       <= 2'd0;
            r_ll        <= 8'd0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_comp  <= n_comp;
            r_pos   <= n_pos;
            r_ll    <= n_ll;
            r_col   <= n_col;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_txt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte <= n_byte;
            r_done <= n_done;
        end
    end

    assign o_txt.valid      = r_out_valid;
    assign o_txt.text_byte  = r_byte;
    assign o_txt.pixel_done = r_done;

endmodule

// ===== src/pixel_to_ppm_text_encoder.sv =====
// Top level of the PPM P3 text encoder: configuration registers, front part,
// pixel queue and back part. Depends on ppm_pkg, ppm_ifs and the ppm_ modules.
//
//   channel   dir   word                                           handshake
//   i_pix     in    red_level, green_level, blue_level (s16 each)  valid/ready
//   o_txt     out   text_byte (8), pixel_done (1)                  valid/ready
//   APB       in    image_width @0x0, line_limit @0x4              psel/penable
//
// The back part emits one text word per cycle while a pixel is queued and
// the output is not stalled; a pixel is 6 to 12 words, set by its digit
// count plus two separators and one trailing space or newline. The front
// part accepts a pixel whenever the two-entry queue has room. Reset is
// synchronous and active low; it restores width 1, limit 70 and starts a
// fresh row. Output stalls hold the word in the output register.
module pixel_to_ppm_text_encoder #(
    parameter int MAX_WIDTH     = ppm_pkg::MAX_WIDTH_DEF,
    parameter int FRACTION_BITS = ppm_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ppm_pix_if.sink                      i_pix,
    ppm_txt_if.source                    o_txt,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppm_pkg::DATA_W-1:0]   pwdata,
    output logic [ppm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    ppm_pkg::t_cfg   r_cfg;
    logic            q_push;
    logic            q_ready;
    logic            q_pop;
    logic            q_valid;
    ppm_pkg::t_pixel q_in;
    ppm_pkg::t_pixel q_head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width <= ppm_pkg::WIDTH_RESET;
            r_cfg.line_limit  <= ppm_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                ppm_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= pwdata[ppm_pkg::WIDTH_W-1:0];
                end
                ppm_pkg::REG_LINE_LIMIT: begin
                    r_cfg.line_limit <= pwdata[ppm_pkg::LIMIT_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ppm_pkg::REG_IMAGE_WIDTH: begin
                prdata = {{(ppm_pkg::DATA_W-ppm_pkg::WIDTH_W){1'b0}}, r_cfg.image_width};
            end
            ppm_pkg::REG_LINE_LIMIT: begin
                prdata = {{(ppm_pkg::DATA_W-ppm_pkg::LIMIT_W){1'b0}}, r_cfg.line_limit};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    ppm_front #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_front (
        .i_pix    (i_pix),
        .i_q_ready(q_ready),
        .o_push   (q_push),
        .o_data   (q_in)
    );

    ppm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_ready(q_ready),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_head (q_head)
    );

    ppm_back #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_valid(q_valid),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_txt       (o_txt)
    );

`ifndef SYNTHESIS
    a_byte_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_txt.valid |-> (o_txt.text_byte == ppm_pkg::CHAR_SPACE ||
                         o_txt.text_byte == ppm_pkg::CHAR_NEWLINE ||
                         (o_txt.text_byte >= ppm_pkg::CHAR_ZERO &&
                          o_txt.text_byte <= (ppm_pkg::CHAR_ZERO + 8'd9))))
        else $error("text word is not a digit, space or newline");

    a_done_on_sep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_txt.valid && o_txt.pixel_done) |->
            (o_txt.text_byte == ppm_pkg::CHAR_SPACE ||
             o_txt.text_byte == ppm_pkg::CHAR_NEWLINE))
        else $error("pixel ends on a digit");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pixel queue popped while empty");
`endif

endmodule

// ===== bench/tb_pixel_to_ppm_text_encoder.sv =====
// Self-checking bench for pixel_to_ppm_text_encoder: predicts the ASCII text of
// each accepted pixel and checks every output word, over many width and limit settings.
// Depends on ppm_pkg, the ppm_pix_if and ppm_txt_if interfaces and the encoder RTL.
module tb_pixel_to_ppm_text_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import ppm_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH = ADDR_W'({REG_IMAGE_WIDTH, 2'b00});
    localparam logic [ADDR_W-1:0] ADDR_LINE_LIMIT  = ADDR_W'({REG_LINE_LIMIT, 2'b00});
    localparam logic [DATA_W-1:0] WIDTH_MASK = (DATA_W'(1) << WIDTH_W) - 1;
    localparam logic [DATA_W-1:0] LIMIT_MASK = (DATA_W'(1) << LIMIT_W) - 1;

    typedef struct {
        logic signed [LEVEL_W-1:0] red;
        logic signed [LEVEL_W-1:0] green;
        logic signed [LEVEL_W-1:0] blue;
    } t_pixel_word;

    typedef struct {
        logic [7:0] text_byte;
        logic       pixel_done;
    } t_text_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    ppm_pix_if pix_if();
    ppm_txt_if txt_if();

    pixel_to_ppm_text_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_txt   (txt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    t_pixel_word pixel_backlog[$];
    t_text_word  pending_text[$];

    logic [WIDTH_W-1:0] width_reg = WIDTH_RESET;
    logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;
    int unsigned column_count = 0;
    int unsigned line_length  = 0;

    bit pix_fire = 1'b0;
    bit txt_fire = 1'b0;
    bit idle_on  = 1'b1;
    int pix_gap   = 0;
    int txt_stall = 0;

    int error_count   = 0;
    int pixels_in     = 0;
    int words_checked = 0;
    int config_writes = 0;
    int phase_count   = 0;

    function automatic void push_text(logic [7:0] ch, logic done);
        t_text_word w;
        w.text_byte  = ch;
        w.pixel_done = done;
        pending_text.push_back(w);
    endfunction

    function automatic void encode_pixel(t_pixel_word p);
        logic [LEVEL_W-1:0] comp [3];
        int unsigned span;
        int unsigned level;
        int unsigned digits;
        comp[0] = p.red;
        comp[1] = p.green;
        comp[2] = p.blue;
        span = (width_reg == 0) ? 1
             : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
        for (int i = 0; i < 3; i++) begin
            if (comp[i][LEVEL_W-1]) begin
                level = 0;
            end else begin
                level = {16'b0, comp[i]} >> (FRACTION_BITS_DEF - 8);
                if (level > 255) level = 255;
            end
            digits = (level >= 100) ? 3 : ((level >= 10) ? 2 : 1);
            if (i > 0) begin
                if (line_length + 1 + digits > limit_reg) begin
                    push_text(CHAR_NEWLINE, 1'b0);
                    line_length = 0;
                end else begin
                    push_text(CHAR_SPACE, 1'b0);
                    line_length += 1;
                end
            end
            if (digits == 3) push_text(8'(CHAR_ZERO + level / 100), 1'b0);
            if (digits >= 2) push_text(8'(CHAR_ZERO + (level / 10) % 10), 1'b0);
            push_text(8'(CHAR_ZERO + level % 10), 1'b0);
            line_length += digits;
        end
        if (column_count + 1 >= span) begin
            push_text(CHAR_NEWLINE, 1'b1);
            line_length  = 0;
            column_count = 0;
        end else begin
            if (line_length + 4 > limit_reg) begin
                push_text(CHAR_NEWLINE, 1'b1);
                line_length = 0;
            end else begin
                push_text(CHAR_SPACE, 1'b1);
                line_length += 1;
            end
            column_count += 1;
        end
        line_length &= 32'hFF;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] random_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return LEVEL_W'($urandom_range(0, 4095));
            5:             return LEVEL_W'($urandom_range(0, 159));
            6:             return LEVEL_W'($urandom_range(0, 1599));
            7:             return -LEVEL_W'($urandom_range(1, 32768));
            8:             return LEVEL_W'($urandom_range(4096, 32767));
            default:       return LEVEL_W'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_text_word want;
        pix_fire = i_rst_n && pix_if.valid && pix_if.ready;
        txt_fire = i_rst_n && txt_if.valid && txt_if.ready;
        if (!i_rst_n) begin
            width_reg    = WIDTH_RESET;
            limit_reg    = LIMIT_RESET;
            column_count = 0;
            line_length  = 0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_IMAGE_WIDTH) width_reg = pwdata[WIDTH_W-1:0];
            else if (paddr == ADDR_LINE_LIMIT) limit_reg = pwdata[LIMIT_W-1:0];
        end
        if (pix_fire) begin
            encode_pixel('{red: pix_if.red_level, green: pix_if.green_level,
                           blue: pix_if.blue_level});
            pixels_in++;
        end
        if (txt_fire) begin
            if (pending_text.size() == 0) begin
                $error("text word with nothing expected: text_byte %02h pixel_done %0b",
                       txt_if.text_byte, txt_if.pixel_done);
                error_count++;
            end else begin
                want = pending_text.pop_front();
                if (txt_if.text_byte !== want.text_byte) begin
                    $error("text_byte mismatch: expected %02h actual %02h",
                           want.text_byte, txt_if.text_byte);
                    error_count++;
                end
                if (txt_if.pixel_done !== want.pixel_done) begin
                    $error("pixel_done mismatch: expected %0b actual %0b",
                           want.pixel_done, txt_if.pixel_done);
                    error_count++;
                end
                words_checked++;
            end
        end
    end

    always @(negedge i_clk) begin
        t_pixel_word w;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || pix_fire) begin
            if (pix_gap > 0 || pixel_backlog.size() == 0) begin
                if (pix_gap > 0) pix_gap--;
                pix_if.valid <= 1'b0;
            end else begin
                w = pixel_backlog.pop_front();
                pix_if.red_level   <= w.red;
                pix_if.green_level <= w.green;
                pix_if.blue_level  <= w.blue;
                pix_if.valid       <= 1'b1;
                pix_gap = idle_on ? $urandom_range(0, 3) : 0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            txt_if.ready <= 1'b0;
        end else begin
            if (txt_fire) txt_stall = idle_on ? $urandom_range(0, 3) : 0;
            if (txt_stall > 0) begin
                txt_stall--;
                txt_if.ready <= 1'b0;
            end else begin
                txt_if.ready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || pix_if.valid || pending_text.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] value,
                                  input logic [DATA_W-1:0] mask);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask)) begin
            $error("prdata mismatch at %0h: expected %0h actual %0h",
                   addr, value & mask, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        config_writes++;
    endtask

    task automatic begin_phase(input bit set_width, input logic [WIDTH_W-1:0] width,
                               input bit set_limit, input logic [LIMIT_W-1:0] limit,
                               input bit idle);
        wait_drained();
        if (set_width) write_register(ADDR_IMAGE_WIDTH, DATA_W'(width), WIDTH_MASK);
        if (set_limit) write_register(ADDR_LINE_LIMIT, DATA_W'(limit), LIMIT_MASK);
        @(posedge i_clk);
        idle_on = idle;
        phase_count++;
    endtask

    task automatic queue_pixel(input logic signed [LEVEL_W-1:0] r,
                               input logic signed [LEVEL_W-1:0] g,
                               input logic signed [LEVEL_W-1:0] b);
        pixel_backlog.push_back('{red: r, green: g, blue: b});
    endtask

    initial begin
        logic [WIDTH_W-1:0] w;
        logic [LIMIT_W-1:0] l;
        bit set_w;
        bit set_l;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_if.valid       = 1'b0;
        pix_if.red_level   = '0;
        pix_if.green_level = '0;
        pix_if.blue_level  = '0;
        txt_if.ready       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first: width 1 and limit 70.
        queue_pixel(16'sd0, 16'sd0, 16'sd0);
        queue_pixel(16'sd32767, -16'sd32768, -16'sd1);
        queue_pixel(16'sd4095, 16'sd4096, 16'sd16);

        // Narrow lines force wraps inside and between pixels.
        begin_phase(1, 13'd4, 1, 8'd10, 1);
        queue_pixel(16'sd1600, 16'sd160, 16'sd16);
        queue_pixel(16'sd1599, 16'sd159, 16'sd15);
        queue_pixel(16'sd4095, 16'sd1600, 16'sd4095);
        queue_pixel(16'sd8, 16'sd32, 16'sd3200);

        begin_phase(0, 13'd0, 1, 8'd3, 0);
        queue_pixel(16'sd4095, 16'sd4095, 16'sd4095);
        queue_pixel(16'sd16, 16'sd160, 16'sd1600);

        // Limits below three still place a token on an empty line.
        begin_phase(0, 13'd0, 1, 8'd1, 1);
        queue_pixel(16'sd160, 16'sd1600, 16'sd0);
        queue_pixel(16'sd1600, 16'sd1600, 16'sd1600);

        // Width zero behaves as one; oversized width is clipped.
        begin_phase(1, 13'd0, 1, 8'd255, 1);
        queue_pixel(16'sd2000, -16'sd100, 16'sd500);
        queue_pixel(16'sd100, 16'sd200, 16'sd300);

        begin_phase(1, 13'h1FFF, 0, 8'd0, 1);
        repeat (5) queue_pixel(16'sd4095, 16'sd4095, 16'sd4095);

        // Lowering the width mid-row ends the row on the next pixel.
        begin_phase(1, 13'd2, 1, 8'd70, 1);
        queue_pixel(16'sd800, 16'sd80, 16'sd8);
        queue_pixel(16'sd3000, 16'sd300, 16'sd30);

        for (int ph = 0; ph < 14; ph++) begin
            set_w = 1'b1;
            set_l = 1'b1;
            w = '0;
            l = '0;
            case ($urandom_range(0, 7))
                0, 1, 2, 3: w = WIDTH_W'($urandom_range(1, 6));
                4:          w = WIDTH_W'($urandom_range(7, 40));
                5:          w = 13'd1;
                6: case ($urandom_range(0, 3))
                       0:       w = 13'd0;
                       1:       w = 13'd4096;
                       2:       w = 13'h1FFF;
                       default: w = 13'd4095;
                   endcase
                default:    set_w = 1'b0;
            endcase
            case ($urandom_range(0, 8))
                0, 1, 2, 3: l = LIMIT_W'($urandom_range(3, 255));
                4:          l = 8'd3;
                5:          l = 8'd255;
                6:          l = LIMIT_W'($urandom_range(4, 16));
                7:          l = LIMIT_W'($urandom_range(0, 2));
                default:    set_l = 1'b0;
            endcase
            begin_phase(set_w, w, set_l, l, $urandom_range(0, 3) != 0);
            repeat (26) queue_pixel(random_level(), random_level(), random_level());
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d pixels and %0d text words over %0d phases",
                 pixels_in, words_checked, phase_count);
        $display("with %0d register writes.", config_writes);
        if (error_count == 0) begin
            $display("PASS pixel_to_ppm_text_encoder");
        end else begin
            $display("FAIL pixel_to_ppm_text_encoder");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL pixel_to_ppm_text_encoder");
        $finish;
    end

endmodule

// ===== pixel_to_ppm_text_encoder.f =====
src/ppm_pkg.sv
src/ppm_ifs.sv
src/ppm_front.sv
src/ppm_queue.sv
src/ppm_back.sv
src/pixel_to_ppm_text_encoder.sv
bench/tb_pixel_to_ppm_text_encoder.sv
